/* rtl/core/text_console_character_writer_defines.svh */
// Assertion macros for the text console character writer checker.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH

// Concurrent property on the rising clock, off while reset is held.
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");

// Same-cycle implication.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  `TCW_ASSERT(lbl, ((ante) |-> (cons)))

`endif

/* rtl/core/tcw_pkg.sv */
// Shared types, constants and helpers for the text console character writer.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;

  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ROW_W:0]    ROW_END    = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W-1:0] COPY_START = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  localparam logic [1:0] OP_PRINT    = 2'd0;
  localparam logic [1:0] OP_WRITE_AT = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  character;
    logic [7:0]  attribute;
    logic [7:0]  column;
    logic [5:0]  row;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [IDX_W-1:0] cursor_index;
    logic [15:0]      read_data;
    logic             scrolled;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Linear cell position: y * COLUMNS + x.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                  input logic [COL_W-1:0] x);
    logic [31:0] full;
    full = 32'(y) * 32'(COLUMNS) + 32'(x);
    return full[ADDR_W-1:0];
  endfunction

  // Cursor index as reported, kept to the result field width.
  function automatic logic [IDX_W-1:0] cursor_idx(input logic [ROW_W-1:0] y,
                                                  input logic [COL_W-1:0] x);
    logic [31:0] full;
    full = 32'(y) * 32'(COLUMNS) + 32'(x);
    return full[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tcw_cell_mem.sv */
// Screen cell store: one write port, one registered read port.
// Depends on tcw_pkg for depth, widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_mem import tcw_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] cells [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= cells[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
// Console sequencer: cursor state, command decode, scroll copy and fill sweeps.
// Depends on tcw_pkg; drives the cell store through a mem_req_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  output mem_req_t          mem_req,
  input  logic [CELL_W-1:0] rd_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_COPY  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_FILL  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [7:0]        last_attr_r, last_attr_nxt;
  logic [7:0]        fill_attr_r, fill_attr_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              oob_r, oob_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [COL_W-1:0]  nx;
  logic [ROW_W:0]    ny;
  logic [15:0]       rdata;
  logic              scr;

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    last_attr_nxt = last_attr_r;
    fill_attr_nxt = fill_attr_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    oob_nxt       = oob_r;
    out_valid_nxt = 1'b0;
    rdata         = '0;
    scr           = 1'b0;
    mem_req       = '0;
    nx            = cur_x_r;
    ny            = {1'b0, cur_y_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.operation)
            OP_PRINT: begin
              priority if (in_data.character == CH_NEWLINE) begin
                nx = '0;
                ny = ny + 1'b1;
              end else if (in_data.character == CH_BACKSPACE) begin
                if (cur_x_r != '0) begin
                  nx = cur_x_r - 1'b1;
                end else if (cur_y_r != '0) begin
                  nx = LAST_COL;
                  ny = ny - 1'b1;
                end
                mem_req.we    = 1'b1;
                mem_req.waddr = cell_addr(ny[ROW_W-1:0], nx);
                mem_req.wdata = {in_data.attribute, CH_BLANK};
                last_attr_nxt = in_data.attribute;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cell_addr(cur_y_r, cur_x_r);
                mem_req.wdata = {in_data.attribute, in_data.character};
                last_attr_nxt = in_data.attribute;
                if (cur_x_r == LAST_COL) begin
                  nx = '0;
                  ny = ny + 1'b1;
                end else begin
                  nx = cur_x_r + 1'b1;
                end
              end
              if (ny == ROW_END) begin
                // past the bottom: copy rows up, then blank the last row
                cur_x_nxt = '0;
                cur_y_nxt = LAST_ROW;
                ptr_nxt   = COPY_START;
                state_nxt = S_COPY;
              end else begin
                cur_x_nxt     = nx;
                cur_y_nxt     = ny[ROW_W-1:0];
                out_valid_nxt = 1'b1;
              end
            end
            OP_WRITE_AT: begin
              if (in_data.column < COLUMNS && in_data.row < ROWS) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cell_addr(in_data.row[ROW_W-1:0],
                                          in_data.column[COL_W-1:0]);
                mem_req.wdata = {in_data.attribute, in_data.character};
                last_attr_nxt = in_data.attribute;
              end
              out_valid_nxt = 1'b1;
            end
            OP_CLEAR: begin
              cur_x_nxt     = '0;
              cur_y_nxt     = '0;
              fill_attr_nxt = in_data.attribute;
              ptr_nxt       = '0;
              state_nxt     = S_CLEAR;
            end
            OP_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ADDR_W'(in_data.cell_index);
              oob_nxt       = (in_data.cell_index >= CELL_COUNT);
              state_nxt     = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        rdata         = oob_r ? '0 : rd_data;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_COPY: begin
        // read ahead one cell; write the previous read one row lower in address
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_r;
        pend_nxt      = 1'b1;
        wr_addr_nxt   = ptr_r - COPY_START;
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_addr_r;
          mem_req.wdata = rd_data;
        end
        if (ptr_r == LAST_CELL) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = rd_data;
        ptr_nxt       = FILL_START;
        state_nxt     = S_FILL;
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = {last_attr_r, CH_BLANK};
        if (ptr_r == LAST_CELL) begin
          scr           = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = {fill_attr_r, CH_BLANK};
        if (ptr_r == LAST_CELL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.cursor_column = cur_x_nxt;
    out_nxt.cursor_row    = cur_y_nxt;
    out_nxt.cursor_index  = cursor_idx(cur_y_nxt, cur_x_nxt);
    out_nxt.read_data     = rdata;
    out_nxt.scrolled      = scr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      last_attr_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      last_attr_r <= last_attr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_attr_r <= fill_attr_nxt;
    ptr_r       <= ptr_nxt;
    wr_addr_r   <= wr_addr_nxt;
    oob_r       <= oob_nxt;
    if (out_valid_nxt) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/core/text_console_character_writer.sv */
// Top level of the text console character writer: sequencer plus cell store.
// Depends on tcw_pkg, tcw_ctrl and tcw_cell_mem.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken on a rising edge with start high and busy low; its result
// appears on out_data with out_valid high for exactly one cycle and cannot be
// held off, so capture it on that cycle. print_char (without scroll) and
// write_at answer on the cycle after start and keep busy low, so a new item may
// follow every cycle. read answers from the S_READ state, after the registered
// read of the cell memory. Scrolling moves one cell per cycle through the single
// write port of the cell memory, with busy held through the copy, drain and fill
// sweeps until the result. clear writes one cell per cycle, also with busy held.
// Cells never written since reset read back as undefined.
module text_console_character_writer import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  mem_req_t          mem_req;
  logic [CELL_W-1:0] rd_data;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  tcw_cell_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* rtl/core/tcw_checker.sv */
// Port-level checks for the text console character writer, bound to the top.
// Depends on tcw_pkg and text_console_character_writer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_character_writer_defines.svh"

module tcw_checker import tcw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // every transfer either answers next cycle or holds busy
  `TCW_ASSERT(a_accept_progress, (start && !busy |=> out_valid || busy))

  // busy drops only together with a result
  `TCW_ASSERT_IMP(a_busy_ends_with_result, $fell(busy), out_valid)

  `TCW_ASSERT_IMP(a_index_matches, out_valid,
    out_data.cursor_index == cursor_idx(out_data.cursor_row, out_data.cursor_column))

  `TCW_ASSERT_IMP(a_scroll_cursor, out_valid && out_data.scrolled,
    out_data.cursor_column == '0 && out_data.cursor_row == LAST_ROW)

  // a read past the store answers zero
  `TCW_ASSERT(a_read_oob_zero, (start && !busy && in_data.operation == OP_READ &&
    in_data.cell_index >= CELL_COUNT |=> ##1 out_valid && out_data.read_data == '0))

endmodule

bind text_console_character_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire

/* tb/tb_text_console_character_writer.sv */
// Self-checking testbench for text_console_character_writer: a directed table, then random
// commands, each result checked against a cycle-free model of the console kept here or
// the fixed report of its table row. Depends on tcw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_text_console_character_writer;
  import tcw_pkg::*;

  typedef struct {
    in_item_t    cmd;
    int unsigned reps;
    bit          fixed;
    out_item_t   want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  // Console model: cell store, cursor and the attribute of the last cell write.
  logic [15:0] cells_m [CELL_COUNT];
  int          cur_x;
  int          cur_y;
  logic [7:0]  last_attr;

  out_item_t   reports_due [$];
  stim_row_t   stim_table [$];
  int unsigned gap_plan [3] = '{17, 65, 0};
  int          fail_count = 0;

  text_console_character_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t mk_item(input logic [1:0] op, input logic [7:0] ch,
                                       input logic [7:0] attr, input logic [7:0] col,
                                       input logic [5:0] row, input logic [10:0] idx);
    in_item_t c;
    c.operation  = op;
    c.character  = ch;
    c.attribute  = attr;
    c.column     = col;
    c.row        = row;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic out_item_t mk_report(input int x, input int y, input int idx,
                                          input logic [15:0] rd, input bit scr);
    out_item_t r;
    r.cursor_column = 7'(x);
    r.cursor_row    = 5'(y);
    r.cursor_index  = 11'(idx);
    r.read_data     = rd;
    r.scrolled      = scr;
    return r;
  endfunction

  function automatic void put_cell(input int x, input int y, input logic [7:0] ch,
                                   input logic [7:0] attr);
    if (x >= COLUMNS || y >= ROWS) return;
    last_attr = attr;
    cells_m[y * COLUMNS + x] = {attr, ch};
  endfunction

  // Apply one command to the console model and return the report it causes.
  function automatic out_item_t console_apply(input in_item_t c);
    logic [15:0] rd;
    bit          scr;
    rd  = '0;
    scr = 1'b0;
    case (c.operation)
      OP_PRINT: begin
        if (c.character == CH_NEWLINE) begin
          cur_x = 0;
          cur_y++;
        end else if (c.character == CH_BACKSPACE) begin
          if (cur_x > 0) begin
            cur_x--;
          end else if (cur_y > 0) begin
            cur_y--;
            cur_x = COLUMNS - 1;
          end
          put_cell(cur_x, cur_y, CH_BLANK, c.attribute);
        end else begin
          put_cell(cur_x, cur_y, c.character, c.attribute);
          cur_x++;
          if (cur_x >= COLUMNS) begin
            cur_x = 0;
            cur_y++;
          end
        end
        if (cur_y >= ROWS) begin
          // shift rows up by one, blank the bottom row in the last attribute
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells_m[i] = cells_m[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells_m[i] = {last_attr, CH_BLANK};
          cur_x = 0;
          cur_y = ROWS - 1;
          scr   = 1'b1;
        end
      end
      OP_WRITE_AT: begin
        put_cell(int'(c.column), int'(c.row), c.character, c.attribute);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) cells_m[i] = {c.attribute, CH_BLANK};
        cur_x = 0;
        cur_y = 0;
      end
      OP_READ: begin
        if (int'(c.cell_index) < CELL_COUNT) rd = cells_m[c.cell_index];
      end
    endcase
    return mk_report(cur_x, cur_y, cur_y * COLUMNS + cur_x, rd, scr);
  endfunction

  // Mostly printing, so the cursor reaches the bottom and scrolls; unused fields carry noise.
  // Reads are safe anywhere: the directed table clears the whole store before any in-range read.
  function automatic in_item_t random_cmd();
    int unsigned pick;
    in_item_t    c;
    pick = $urandom_range(0, 99);
    c = mk_item(OP_PRINT, 8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
                11'($urandom));
    if (pick < 7) begin
      c.character = CH_NEWLINE;
    end else if (pick < 15) begin
      c.character = CH_BACKSPACE;
    end else if (pick < 30) begin
      c.operation = OP_WRITE_AT;
      if ($urandom_range(0, 3) != 0) begin
        c.column = 8'($urandom_range(0, COLUMNS - 1));
        c.row    = 6'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 44) begin
      c.operation = OP_READ;
      if ($urandom_range(0, 7) != 0) c.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
    end else if (pick == 44) begin
      c.operation = OP_CLEAR;
    end
    return c;
  endfunction

  function automatic void add_row(input in_item_t c, input int unsigned reps, input bit fixed,
                                  input out_item_t want);
    stim_row_t r;
    r.cmd   = c;
    r.reps  = reps;
    r.fixed = fixed;
    r.want  = want;
    stim_table.push_back(r);
  endfunction

  // Hold start until the transfer, then record the report it must cause.
  task automatic send_cmd(input in_item_t c, input int unsigned gap_pct, input bit fixed,
                          input out_item_t want);
    out_item_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= c;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    r = console_apply(c);
    reports_due.push_back(fixed ? want : r);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (reports_due.size() == 0) begin
        $error("result with no command outstanding");
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        if (out_data.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d", want.cursor_column,
                 out_data.cursor_column);
          fail_count++;
        end
        if (out_data.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_data.cursor_row);
          fail_count++;
        end
        if (out_data.cursor_index !== want.cursor_index) begin
          $error("cursor_index: expected %0d, got %0d", want.cursor_index,
                 out_data.cursor_index);
          fail_count++;
        end
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
          fail_count++;
        end
        if (out_data.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, out_data.scrolled);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned drain;
    out_item_t   none;
    none      = '0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cur_x     = 0;
    cur_y     = 0;
    last_attr = '0;

    // read past the store straight out of reset, then blank everything
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd2047), 1, 1,
            mk_report(0, 0, 0, 16'h0000, 0));
    add_row(mk_item(OP_CLEAR, 8'h00, 8'hFF, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(0, 0, 0, 16'h0000, 0));
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(0, 0, 0, 16'hFF20, 0));
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd1999), 1, 1,
            mk_report(0, 0, 0, 16'hFF20, 0));
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd2000), 1, 1,
            mk_report(0, 0, 0, 16'h0000, 0));
    // backspace at the origin stays put and blanks cell 0
    add_row(mk_item(OP_PRINT, CH_BACKSPACE, 8'h00, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(0, 0, 0, 16'h0000, 0));
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(0, 0, 0, 16'h0020, 0));
    add_row(mk_item(OP_PRINT, 8'hFF, 8'hFF, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(1, 0, 1, 16'h0000, 0));
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(1, 0, 1, 16'hFFFF, 0));
    add_row(mk_item(OP_PRINT, 8'h00, 8'h00, 8'hFF, 6'h3F, 11'h7FF), 1, 0, none);
    add_row(mk_item(OP_PRINT, CH_BACKSPACE, 8'h5A, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_PRINT, CH_NEWLINE, 8'hA5, 8'h00, 6'h00, 11'd0), 1, 0, none);
    // backspace from column 0 goes to the end of the row above, then wrap back down
    add_row(mk_item(OP_PRINT, CH_BACKSPACE, 8'h33, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_PRINT, 8'h41, 8'h71, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_WRITE_AT, 8'h5A, 8'hC4, 8'd79, 6'd24, 11'd0), 1, 0, none);
    add_row(mk_item(OP_WRITE_AT, 8'h11, 8'h99, 8'd80, 6'd0, 11'd0), 1, 0, none);
    add_row(mk_item(OP_WRITE_AT, 8'h22, 8'h98, 8'd255, 6'd63, 11'd0), 1, 0, none);
    add_row(mk_item(OP_WRITE_AT, 8'h33, 8'h97, 8'd0, 6'd25, 11'd0), 1, 0, none);
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd1999), 1, 0, none);
    // walk down to the last row, then one more newline scrolls
    add_row(mk_item(OP_PRINT, CH_NEWLINE, 8'h00, 8'h00, 6'h00, 11'd0), 23, 0, none);
    add_row(mk_item(OP_PRINT, CH_NEWLINE, 8'h00, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_PRINT, CH_BACKSPACE, 8'h1E, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_PRINT, 8'h78, 8'h2B, 8'h00, 6'h00, 11'd0), 1, 0, none);
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd1920), 1, 0, none);
    add_row(mk_item(OP_READ, 8'h00, 8'h00, 8'h00, 6'h00, 11'd1919), 1, 0, none);
    add_row(mk_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 6'h00, 11'd0), 1, 1,
            mk_report(0, 0, 0, 16'h0000, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      for (int n = 0; n < int'(stim_table[i].reps); n++)
        send_cmd(stim_table[i].cmd, 17, stim_table[i].fixed, stim_table[i].want);

    for (int p = 0; p < 3; p++)
      for (int n = 0; n < 540; n++)
        send_cmd(random_cmd(), gap_plan[p], 1'b0, none);

    start <= 1'b0;
    drain = 0;
    while (reports_due.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (reports_due.size() != 0) begin
      $error("%0d results never arrived", reports_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
